// File: src/flrl_pkg.sv
`default_nettype none

package flrl_pkg;

  localparam int unsigned DEF_ENTRIES  = 16;
  localparam int unsigned DEF_KEY_BITS = 64;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CLIENT_W = 64;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_IDX_W = 4;
  localparam int unsigned FAIL_W   = 8;
  localparam int unsigned COOL_W   = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [FAIL_W-1:0] MAX_FAIL_RST = 8'd5;
  localparam logic [COOL_W-1:0] COOLDOWN_RST = 16'd60;
  localparam logic [FAIL_W-1:0] FAIL_SAT     = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK  = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_LOCKED  = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FAILURES = 1'b0,
    CFG_COOLDOWN     = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_LAST   = 2'd2,
    S_DECIDE = 2'd3
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [CLIENT_W-1:0] client_key;
    logic [TIME_W-1:0]   now_seconds;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] entry_index;
    logic [FAIL_W-1:0]    failure_count;
  } rsp_t;

endpackage

`default_nettype wire

// File: src/failure_lockout_rate_limiter.sv
`default_nettype none

// per-client failure lockout table
// request channel: req_i is taken at a rising edge with start high and busy low
// commands: check a client, record a failure, clear the whole table
// result channel: rsp_o is valid for exactly one cycle with res_valid_o high;
// the receiver cannot stall, so results are never held back
// clear and invalid requests (zero key, reserved command) answer in the cycle after
// acceptance without a table scan and leave busy low
// check and record scan every entry through one key comparator, one entry per
// cycle, from a table memory with separate read and write ports; busy stays
// high through S_SCAN, S_LAST and S_DECIDE; the result strobe is registered from S_DECIDE
// the next request may be accepted in the cycle the result strobe is high
// configuration writes (cfg_we_i) take effect at the edge; issue them only idle
// reset empties the table at once through per-entry valid bits, restores
// max_failures to 5 and cooldown_seconds to 60, and needs no clearing pass
module failure_lockout_rate_limiter #(
  parameter int unsigned ENTRIES  = flrl_pkg::DEF_ENTRIES,
  parameter int unsigned KEY_BITS = flrl_pkg::DEF_KEY_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire flrl_pkg::req_t                req_i,
  output logic                               res_valid_o,
  output flrl_pkg::rsp_t                     rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [flrl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [flrl_pkg::CFG_W-1:0]    cfg_wdata_i
);

  import flrl_pkg::*;

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WORD_W = KEY_BITS + FAIL_W + TIME_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_e state_q, state_d;

  logic [IDX_W-1:0]    scan_idx_q, scan_idx_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic                pend_q, pend_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic                hit_q, hit_d;
  logic [IDX_W-1:0]    hit_idx_q, hit_idx_d;
  logic [FAIL_W-1:0]   hit_fail_q, hit_fail_d;
  logic [TIME_W-1:0]   hit_time_q, hit_time_d;
  logic                free_q, free_d;
  logic [IDX_W-1:0]    free_idx_q, free_idx_d;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [FAIL_W-1:0]   max_fail_q;
  logic [COOL_W-1:0]   cooldown_q;
  logic                res_valid_q, res_valid_d;
  rsp_t                rsp_q, rsp_d;

  logic                accept;
  logic [KEY_BITS-1:0] key_in;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [FAIL_W-1:0]   rd_fail;
  logic [TIME_W-1:0]   rd_time;
  logic                ent_valid;
  logic                match;
  logic                ent_free;
  logic [TIME_W-1:0]   elapsed;
  logic                over_limit;
  logic                in_cooldown;
  logic [IDX_W-1:0]    tgt_idx;
  logic [FAIL_W-1:0]   base_fail;
  logic [FAIL_W-1:0]   new_fail;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign key_in      = req_i.client_key[KEY_BITS-1:0];
  assign res_valid_o = res_valid_q;
  assign rsp_o       = rsp_q;

  flrl_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(scan_idx_q),
    .rdata_o(ram_rdata)
  );

  assign rd_key  = ram_rdata[WORD_W-1 -: KEY_BITS];
  assign rd_fail = ram_rdata[TIME_W +: FAIL_W];
  assign rd_time = ram_rdata[TIME_W-1:0];

  // shared comparator, one entry per cycle
  assign ent_valid = valid_q[cmp_idx_q];
  assign match     = pend_q && ent_valid && (rd_key == key_q);
  assign ent_free  = pend_q && !ent_valid;

  assign elapsed     = now_q - hit_time_q;
  assign over_limit  = (hit_fail_q >= max_fail_q);
  assign in_cooldown = (elapsed < {{(TIME_W-COOL_W){1'b0}}, cooldown_q});
  assign tgt_idx     = hit_q ? hit_idx_q : free_idx_q;
  assign base_fail   = hit_q ? hit_fail_q : '0;
  assign new_fail    = (base_fail == FAIL_SAT) ? base_fail : base_fail + 8'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (key_in != '0) &&
            (cmd_e'(req_i.command) inside {CMD_CHECK, CMD_RECORD})) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx_q == LAST_IDX) begin
          state_d = S_LAST;
        end
      end
      S_LAST:   state_d = S_DECIDE;
      S_DECIDE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    scan_idx_d  = scan_idx_q;
    cmp_idx_d   = cmp_idx_q;
    pend_d      = 1'b0;
    cmd_d       = cmd_q;
    key_d       = key_q;
    now_d       = now_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_fail_d  = hit_fail_q;
    hit_time_d  = hit_time_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    valid_d     = valid_q;
    res_valid_d = 1'b0;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = hit_idx_q;
    ram_wdata   = {key_q, {FAIL_W{1'b0}}, hit_time_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d      = req_i.command;
          key_d      = key_in;
          now_d      = req_i.now_seconds;
          scan_idx_d = '0;
          hit_d      = 1'b0;
          free_d     = 1'b0;
          case (cmd_e'(req_i.command))
            CMD_CLEAR: begin
              valid_d     = '0;
              res_valid_d = 1'b1;
              rsp_d       = '{status: ST_OK, entry_index: '0, failure_count: '0};
            end
            CMD_CHECK, CMD_RECORD: begin
              if (key_in == '0) begin
                res_valid_d = 1'b1;
                rsp_d = '{status: ST_INVALID, entry_index: '0, failure_count: '0};
              end
            end
            default: begin
              res_valid_d = 1'b1;
              rsp_d = '{status: ST_INVALID, entry_index: '0, failure_count: '0};
            end
          endcase
        end
      end
      S_SCAN: begin
        pend_d    = 1'b1;
        cmp_idx_d = scan_idx_q;
        if (scan_idx_q != LAST_IDX) begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      S_LAST: begin
      end
      S_DECIDE: begin
        res_valid_d = 1'b1;
        if (cmd_e'(cmd_q) == CMD_CHECK) begin
          if (!hit_q) begin
            rsp_d = '{status: (free_q ? ST_OK : ST_FULL), entry_index: '0,
                      failure_count: '0};
          end else if (over_limit && in_cooldown) begin
            rsp_d = '{status: ST_LOCKED, entry_index: OUT_IDX_W'(hit_idx_q),
                      failure_count: hit_fail_q};
          end else if (over_limit) begin
            // cooldown over, counter drops to zero
            ram_we    = 1'b1;
            ram_waddr = hit_idx_q;
            ram_wdata = {key_q, {FAIL_W{1'b0}}, hit_time_q};
            rsp_d = '{status: ST_OK, entry_index: OUT_IDX_W'(hit_idx_q),
                      failure_count: '0};
          end else begin
            rsp_d = '{status: ST_OK, entry_index: OUT_IDX_W'(hit_idx_q),
                      failure_count: hit_fail_q};
          end
        end else begin
          if (!hit_q && !free_q) begin
            rsp_d = '{status: ST_FULL, entry_index: '0, failure_count: '0};
          end else begin
            ram_we           = 1'b1;
            ram_waddr        = tgt_idx;
            ram_wdata        = {key_q, new_fail, now_q};
            valid_d[tgt_idx] = 1'b1;
            rsp_d = '{status: ST_OK, entry_index: OUT_IDX_W'(tgt_idx),
                      failure_count: new_fail};
          end
        end
      end
      default: begin
      end
    endcase

    if (match && !hit_q) begin
      hit_d      = 1'b1;
      hit_idx_d  = cmp_idx_q;
      hit_fail_d = rd_fail;
      hit_time_d = rd_time;
    end
    if (ent_free && !free_q) begin
      free_d     = 1'b1;
      free_idx_d = cmp_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
      max_fail_q  <= MAX_FAIL_RST;
      cooldown_q  <= COOLDOWN_RST;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      valid_q     <= valid_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_FAILURES: max_fail_q <= cfg_wdata_i[FAIL_W-1:0];
          CFG_COOLDOWN:     cooldown_q <= cfg_wdata_i[COOL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    now_q      <= now_d;
    hit_idx_q  <= hit_idx_d;
    hit_fail_q <= hit_fail_d;
    hit_time_q <= hit_time_d;
    free_idx_q <= free_idx_d;
    rsp_q      <= rsp_d;
  end

`ifndef SYNTH
  a_decide_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |=> res_valid_o)
    else $error("no result after table decision");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.command == CMD_CLEAR)) |=> (valid_q == '0))
    else $error("clear left valid entries");

  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> valid_q[hit_idx_q])
    else $error("hit on an empty entry");

  a_no_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !res_valid_o)
    else $error("result strobe during scan");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> (scan_idx_q == '0) && !hit_q && !free_q)
    else $error("scan started from stale state");
`endif

endmodule

`default_nettype wire

// File: src/flrl_ram.sv
`default_nettype none

module flrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

module tb_top;
  import flrl_pkg::*;

  localparam int unsigned SLOTS = DEF_ENTRIES;
  localparam int unsigned POOL = 20;
  localparam int unsigned PHASE_REQUESTS = 130;
  localparam int unsigned SETTLE_CYCLES = DEF_ENTRIES + 8;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } vector_t;

  typedef struct {
    logic [CFG_W-1:0]  fail_word;
    logic [COOL_W-1:0] cool;
  } limits_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  req_t             req_i = '0;
  logic             res_valid_o;
  rsp_t             rsp_o;
  logic             cfg_we_i = 1'b0;
  cfg_idx_e         cfg_idx_i = CFG_MAX_FAILURES;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  failure_lockout_rate_limiter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // lockout table as the testbench sees it
  logic [CLIENT_W-1:0] slot_key   [SLOTS];
  logic [FAIL_W-1:0]   slot_fails [SLOTS];
  logic [TIME_W-1:0]   slot_stamp [SLOTS];
  logic [FAIL_W-1:0]   lockout_threshold;
  logic [COOL_W-1:0]   cooldown;

  logic [CLIENT_W-1:0] pool [POOL];
  logic [TIME_W-1:0]   clock_now;
  vector_t             plan [$];
  limits_t             limits [9];

  rsp_t        pending [$];
  int unsigned mismatches = 0;
  int unsigned strays = 0;
  int unsigned checked = 0;
  int unsigned sent = 0;
  int unsigned by_status [4] = '{0, 0, 0, 0};

  function automatic void forget_all();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      slot_key[i] = '0;
      slot_fails[i] = '0;
      slot_stamp[i] = '0;
    end
  endfunction

  function automatic rsp_t predict_lockout(req_t r);
    rsp_t res;
    int hit;
    int vacant;
    int i;
    logic [TIME_W-1:0] elapsed;
    res = '0;
    res.status = ST_OK;
    hit = -1;
    vacant = -1;
    if (r.command == CMD_CLEAR) begin
      forget_all();
      return res;
    end
    if (r.command == CMD_RSVD || r.client_key == '0) begin
      res.status = ST_INVALID;
      return res;
    end
    for (i = 0; i < SLOTS; i++) begin
      if (slot_key[i] == '0) begin
        if (vacant < 0) vacant = i;
      end else if (slot_key[i] == r.client_key && hit < 0) begin
        hit = i;
      end
    end
    if (r.command == CMD_CHECK) begin
      if (hit < 0) begin
        if (vacant < 0) res.status = ST_FULL;
        return res;
      end
      if (slot_fails[hit] >= lockout_threshold) begin
        elapsed = r.now_seconds - slot_stamp[hit];
        if (elapsed < cooldown) begin
          res.status = ST_LOCKED;
          res.entry_index = OUT_IDX_W'(hit);
          res.failure_count = slot_fails[hit];
          return res;
        end
        slot_fails[hit] = '0;
      end
      res.entry_index = OUT_IDX_W'(hit);
      res.failure_count = slot_fails[hit];
      return res;
    end
    if (hit < 0) begin
      if (vacant < 0) begin
        res.status = ST_FULL;
        return res;
      end
      hit = vacant;
      slot_key[hit] = r.client_key;
      slot_fails[hit] = '0;
    end
    if (slot_fails[hit] != FAIL_SAT) slot_fails[hit] = slot_fails[hit] + 1'b1;
    slot_stamp[hit] = r.now_seconds;
    res.entry_index = OUT_IDX_W'(hit);
    res.failure_count = slot_fails[hit];
    return res;
  endfunction

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && res_valid_o) begin
      if (pending.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10) begin
          $display("%0t: result with no request waiting: status %0d index %0d count %0d",
                   $time, rsp_o.status, rsp_o.entry_index, rsp_o.failure_count);
        end
      end else begin
        want = pending.pop_front();
        checked++;
        if (rsp_o.status !== want.status || rsp_o.entry_index !== want.entry_index ||
            rsp_o.failure_count !== want.failure_count) begin
          mismatches++;
          if (mismatches + strays <= 10) begin
            $display("%0t: result %0d expected status %0d index %0d count %0d, got %0d %0d %0d",
                     $time, checked, want.status, want.entry_index, want.failure_count,
                     rsp_o.status, rsp_o.entry_index, rsp_o.failure_count);
          end
        end
      end
    end
  end

  task automatic plan_row(input cmd_e c, input logic [CLIENT_W-1:0] k,
                          input logic [TIME_W-1:0] t, input bit typed = 1'b0,
                          input status_e s = ST_OK, input logic [OUT_IDX_W-1:0] idx = '0,
                          input logic [FAIL_W-1:0] cnt = '0);
    vector_t v;
    v.req.command = c;
    v.req.client_key = k;
    v.req.now_seconds = t;
    v.typed = typed;
    v.rsp.status = s;
    v.rsp.entry_index = idx;
    v.rsp.failure_count = cnt;
    plan.push_back(v);
  endtask

  task automatic issue(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t predicted;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = predict_lockout(r);
    pending.push_back(typed ? typed_rsp : predicted);
    by_status[predicted.status]++;
    sent++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_limits(input limits_t lim);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MAX_FAILURES;
    cfg_wdata_i <= lim.fail_word;
    @(posedge clk_i);
    cfg_idx_i <= CFG_COOLDOWN;
    cfg_wdata_i <= lim.cool;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lockout_threshold = lim.fail_word[FAIL_W-1:0];
    cooldown = lim.cool;
  endtask

  task automatic random_request(output req_t r);
    int unsigned pick;
    int i;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] offset;
    r = '0;
    pick = $urandom_range(0, 99);
    clock_now = clock_now + $urandom_range(0, 3);
    if ($urandom_range(0, 19) == 0) clock_now = clock_now + cooldown + $urandom_range(0, 2);
    r.now_seconds = clock_now;
    r.client_key = $urandom_range(0, 1) ? pool[$urandom_range(0, 3)]
                                        : pool[$urandom_range(0, POOL - 1)];
    if (pick == 0) begin
      r.command = CMD_CLEAR;
      r.client_key = {$urandom(), $urandom()};
    end else if (pick < 3) begin
      r.command = CMD_RSVD;
      r.client_key = {$urandom(), $urandom()};
    end else if (pick < 6) begin
      r.command = CMD_W'($urandom_range(0, 1));
      r.client_key = '0;
    end else if (pick < 9) begin
      r.command = CMD_W'($urandom_range(0, 1));
      r.client_key = {$urandom(), $urandom()};
    end else if (pick < 53) begin
      r.command = CMD_RECORD;
    end else begin
      r.command = CMD_CHECK;
    end
    // aim checks at the edge of the cooldown window
    if (r.command == CMD_CHECK) begin
      span = cooldown;
      for (i = 0; i < SLOTS; i++) begin
        if (slot_key[i] == r.client_key && r.client_key != '0) begin
          case ($urandom_range(0, 6))
            0: offset = 0;
            1: offset = 1;
            2: offset = span - 1;
            3: offset = span;
            4: offset = span + 1;
            5: offset = $urandom_range(0, 2 * span + 2);
            default: offset = $urandom();
          endcase
          r.now_seconds = slot_stamp[i] + offset;
        end
      end
    end
    if ($urandom_range(0, 49) == 0) r.now_seconds = $urandom();
  endtask

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    req_t r;
    rsp_t none;
    int unsigned gap_pct;
    int unsigned n;
    int p;
    none = '0;
    pool[0] = '1;
    pool[1] = 64'h1;
    for (p = 2; p < POOL; p++) pool[p] = {$urandom(), $urandom()} | 64'h100;
    forget_all();
    lockout_threshold = MAX_FAIL_RST;
    cooldown = COOLDOWN_RST;
    limits = '{'{16'd1, 16'd1}, '{16'd3, 16'd60}, '{16'd255, 16'd65535},
               '{16'd0, 16'd25}, '{16'd2, 16'd0}, '{16'hFF04, 16'd500},
               '{16'd5, 16'd65535}, '{16'd1, 16'd0}, '{16'd4, 16'd90}};

    plan_row(CMD_CHECK, 64'h1, 32'd100, 1'b1, ST_OK, 4'd0, 8'd0);
    plan_row(CMD_CHECK, 64'h0, 32'd0, 1'b1, ST_INVALID, 4'd0, 8'd0);
    plan_row(CMD_RECORD, 64'h0, 32'hFFFF_FFFF, 1'b1, ST_INVALID, 4'd0, 8'd0);
    plan_row(CMD_RSVD, '1, 32'd7, 1'b1, ST_INVALID, 4'd0, 8'd0);
    plan_row(CMD_RSVD, 64'h0, 32'd7, 1'b1, ST_INVALID, 4'd0, 8'd0);
    plan_row(CMD_RECORD, '1, 32'hFFFF_FFF0, 1'b1, ST_OK, 4'd0, 8'd1);
    plan_row(CMD_RECORD, '1, 32'hFFFF_FFF8);
    plan_row(CMD_RECORD, '1, 32'hFFFF_FFFC);
    plan_row(CMD_RECORD, '1, 32'hFFFF_FFFE);
    plan_row(CMD_RECORD, '1, 32'hFFFF_FFFF);
    // lockout across the time wrap, then a failure while locked out
    plan_row(CMD_CHECK, '1, 32'h0000_003A);
    plan_row(CMD_RECORD, '1, 32'h0);
    plan_row(CMD_CHECK, '1, 32'd59);
    plan_row(CMD_CHECK, '1, 32'd60);
    plan_row(CMD_RECORD, 64'h1, 32'h1234);
    plan_row(CMD_RECORD, 64'h8000_0000_0000_0000, 32'h55);
    plan_row(CMD_CHECK, 64'h1, 32'h1235);
    plan_row(CMD_CLEAR, 64'hA5A5_5A5A_0F0F_F0F0, 32'h0, 1'b1, ST_OK, 4'd0, 8'd0);
    plan_row(CMD_CHECK, '1, 32'd60, 1'b1, ST_OK, 4'd0, 8'd0);
    plan_row(CMD_RECORD, 64'h1, 32'd61);
    plan_row(CMD_CLEAR, 64'h0, 32'hFFFF_FFFF, 1'b1, ST_OK, 4'd0, 8'd0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      issue(plan[i].req, plan[i].typed, plan[i].rsp);
      if ($urandom_range(0, 99) < 20) pause_sender($urandom_range(1, 18));
    end

    for (p = 0; p < $size(limits); p++) begin
      settle();
      program_limits(limits[p]);
      clock_now = (p == 1) ? 32'hFFFF_FF00 : $urandom();
      if (limits[p].fail_word[FAIL_W-1:0] == FAIL_SAT) begin
        repeat (260) begin
          clock_now = clock_now + 1;
          r.command = CMD_RECORD;
          r.client_key = pool[0];
          r.now_seconds = clock_now;
          issue(r, 1'b0, none);
        end
      end
      gap_pct = 0;
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 15;
            default: gap_pct = 40;
          endcase
          if (p == $size(limits) - 1) gap_pct = 0;
        end
        random_request(r);
        issue(r, 1'b0, none);
        if ($urandom_range(0, 99) < gap_pct) pause_sender($urandom_range(1, 18));
      end
    end

    settle();
    $display("covered %0d requests, reset values plus %0d register settings, %0d results checked",
             sent, $size(limits), checked);
    $display("outcomes: %0d ok, %0d locked out, %0d table full, %0d invalid; %0d bad, %0d stray",
             by_status[ST_OK], by_status[ST_LOCKED], by_status[ST_FULL],
             by_status[ST_INVALID], mismatches, strays);
    if (mismatches == 0 && strays == 0 && pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
